// File: sv/lsbgd_pkg.sv
package lsbgd_pkg;

  localparam int IndexBitsDef   = 16;
  localparam int CordicStepsDef = 24;
  localparam int CfgIdxW        = 8;
  localparam logic [23:0] InvGain = 24'd10188014;

  localparam logic [CfgIdxW-1:0] RegFreqStep  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegBandRatio = 8'd1;
  localparam logic [CfgIdxW-1:0] RegMagScale  = 8'd2;
  localparam logic [CfgIdxW-1:0] RegDelayComp = 8'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FREQ, ST_BMUL, ST_BCMP, ST_CINIT, ST_CITER, ST_MAG, ST_DMUL, ST_UPD,
    ST_DIVF_GO, ST_DIVF_WT, ST_DIVM_GO, ST_DIVM_WT, ST_SMUL, ST_DIVG_GO, ST_DIVG_WT,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    DIV_FREQ, DIV_MAG, DIV_GD
  } div_sel_e;

  typedef struct packed {
    logic     capture;
    logic     freq;
    logic     bmul;
    logic     band_open;
    logic     cinit;
    logic     citer;
    logic     mag;
    logic     dmul;
    logic     upd;
    logic     div_start;
    div_sel_e div_sel;
    logic     lat_f;
    logic     smul;
    logic     emit;
    logic     emit_last;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic cord_done;
    logic div_busy;
    logic out_free;
    logic last;
  } sts_t;

  // atan(2^-i) in turns, Q0.32
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: sv/log_spectrum_binner_group_delay_core.sv
// Log-spaced spectrum binner. Bins are to enter one transfer at a time in
// ascending index order; the block itself does not enforce it. Each usable
// bin gets magnitude and phase from an iterative CORDIC (one rotation per
// cycle), has the delay term removed from its phase, and is folded into the
// open band. A band closes when a bin's frequency passes band start times
// band_ratio, and a bin marked last_bin flushes the open band, so one input
// transfer gives up to two result transfers. A usable bin without a band
// close runs the frequency, band test, CORDIC, magnitude, delay and update
// steps before the next transfer is accepted; an unusable bin without flush
// leaves the block idle. Each result takes three passes of the shared
// one-bit-per-cycle divider (mean frequency, mean magnitude, group delay) on
// a 40 + INDEX_BITS bit dividend, with the scale multiply between the
// magnitude and group-delay passes, then a load of the output register. That
// load waits while an earlier result is still stalled. Input stall is low
// only when the block is idle; a finished result waits in the output
// register and does not hold off the next input. Configuration writes are
// always ready and must be made while the block is idle.
module log_spectrum_binner_group_delay_core #(
  parameter int INDEX_BITS   = lsbgd_pkg::IndexBitsDef,
  parameter int CORDIC_STEPS = lsbgd_pkg::CordicStepsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsbgd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  // bin input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [23:0]            re_part_i,
  input  logic signed [23:0]            im_part_i,
  input  logic [INDEX_BITS-1:0]         bin_index_i,
  input  logic                          finite_i,
  input  logic                          last_bin_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   mean_freq_o,
  output logic [39:0]                   mean_mag_o,
  output logic signed [31:0]            group_delay_o,
  output logic [31:0]                   indeterminate_total_o,
  output logic [31:0]                   unwrap_total_o,
  output logic                          last_row_o
);
  import lsbgd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, CORDIC loop, band-close divisions, result transfer
  lsbgd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .finite_i   (finite_i),
    .last_bin_i (last_bin_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic, band state, config registers and result register
  lsbgd_dp #(
    .INDEX_BITS   (INDEX_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .re_part_i             (re_part_i),
    .im_part_i             (im_part_i),
    .bin_index_i           (bin_index_i),
    .finite_i              (finite_i),
    .last_bin_i            (last_bin_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .mean_freq_o           (mean_freq_o),
    .mean_mag_o            (mean_mag_o),
    .group_delay_o         (group_delay_o),
    .indeterminate_total_o (indeterminate_total_o),
    .unwrap_total_o        (unwrap_total_o),
    .last_row_o            (last_row_o),
    .cmd_i                 (cmd),
    .sts_o                 (sts)
  );
endmodule

// File: sv/lsbgd_div.sv
module lsbgd_div #(
  parameter int DW = 56,
  parameter int VW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o
);
  localparam int CntW = $clog2(DW + 1);

  logic [VW-1:0]   rem_q, rem_d, dvs_q;
  logic [DW-1:0]   quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [VW:0]     trial;
  logic            fits;

  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CntW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = VW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[VW-1:0];
      end
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;
endmodule

// File: sv/lsbgd_ctrl.sv
module lsbgd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          finite_i,
  input  logic          last_bin_i,
  output logic          in_stall_o,
  input  lsbgd_pkg::sts_t sts_i,
  output lsbgd_pkg::cmd_t cmd_o
);
  import lsbgd_pkg::*;

  state_e state_q, state_d;
  logic   flush_q, flush_d;

  always_comb begin
    state_d = state_q;
    flush_d = flush_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (finite_i) begin
            state_d = ST_FREQ;
          end else if (last_bin_i) begin
            state_d = ST_DIVF_GO;
            flush_d = 1'b1;
          end
        end
      end
      ST_FREQ:  state_d = ST_BMUL;
      ST_BMUL:  state_d = ST_BCMP;
      ST_BCMP: begin
        if (sts_i.close) begin
          state_d = ST_DIVF_GO;
          flush_d = 1'b0;
        end else begin
          state_d = ST_CINIT;
        end
      end
      ST_CINIT: state_d = ST_CITER;
      ST_CITER: begin
        if (sts_i.cord_done) begin
          state_d = ST_MAG;
        end
      end
      ST_MAG:   state_d = ST_DMUL;
      ST_DMUL:  state_d = ST_UPD;
      ST_UPD: begin
        if (sts_i.last) begin
          state_d = ST_DIVF_GO;
          flush_d = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIVF_GO: state_d = ST_DIVF_WT;
      ST_DIVF_WT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_DIVM_GO;
        end
      end
      ST_DIVM_GO: state_d = ST_DIVM_WT;
      ST_DIVM_WT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_SMUL;
        end
      end
      ST_SMUL:    state_d = ST_DIVG_GO;
      ST_DIVG_GO: state_d = ST_DIVG_WT;
      ST_DIVG_WT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = flush_q ? ST_IDLE : ST_CINIT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_FREQ;
    in_stall_o    = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE:    cmd_o.capture = in_valid_i;
      ST_FREQ:    cmd_o.freq = 1'b1;
      ST_BMUL:    cmd_o.bmul = 1'b1;
      ST_BCMP:    cmd_o.band_open = !sts_i.close;
      ST_CINIT:   cmd_o.cinit = 1'b1;
      ST_CITER:   cmd_o.citer = 1'b1;
      ST_MAG:     cmd_o.mag = 1'b1;
      ST_DMUL:    cmd_o.dmul = 1'b1;
      ST_UPD:     cmd_o.upd = 1'b1;
      ST_DIVF_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_FREQ;
      end
      ST_DIVM_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_MAG;
        cmd_o.lat_f     = 1'b1;
      end
      ST_SMUL:    cmd_o.smul = 1'b1;
      ST_DIVG_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_GD;
      end
      ST_EMIT: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_last = flush_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flush_q <= flush_d;
    end
  end

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy) else $error("divider restarted while busy");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free) else $error("result loaded over pending result");
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sts_i.div_busy) |-> $past(cmd_o.div_start)) else $error("divider ran unasked");
`endif
endmodule

// File: sv/lsbgd_dp.sv
module lsbgd_dp #(
  parameter int INDEX_BITS   = lsbgd_pkg::IndexBitsDef,
  parameter int CORDIC_STEPS = lsbgd_pkg::CordicStepsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsbgd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic signed [23:0]            re_part_i,
  input  logic signed [23:0]            im_part_i,
  input  logic [INDEX_BITS-1:0]         bin_index_i,
  input  logic                          finite_i,
  input  logic                          last_bin_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   mean_freq_o,
  output logic [39:0]                   mean_mag_o,
  output logic signed [31:0]            group_delay_o,
  output logic [31:0]                   indeterminate_total_o,
  output logic [31:0]                   unwrap_total_o,
  output logic                          last_row_o,
  input  lsbgd_pkg::cmd_t               cmd_i,
  output lsbgd_pkg::sts_t               sts_o
);
  import lsbgd_pkg::*;

  localparam int SumW = 32 + INDEX_BITS;
  localparam int PhW  = 24 + INDEX_BITS;
  localparam int DW   = PhW + 16;
  localparam int XW   = 35;
  localparam int MW   = XW + 24;
  localparam int CW   = $clog2(CORDIC_STEPS);

  // configuration
  logic [31:0] freq_step_q, delay_q;
  logic [23:0] band_ratio_q, mag_scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_step_q  <= 32'd256;
      band_ratio_q <= 24'd69433;
      mag_scale_q  <= 24'd65536;
      delay_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFreqStep:  freq_step_q  <= cfg_data_i;
        RegBandRatio: band_ratio_q <= cfg_data_i[23:0];
        RegMagScale:  mag_scale_q  <= cfg_data_i[23:0];
        RegDelayComp: delay_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured item
  logic signed [23:0]    re_q, im_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic                  last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      re_q  <= re_part_i;
      im_q  <= im_part_i;
      idx_q <= bin_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (cmd_i.capture) begin
      last_q <= last_bin_i & finite_i;
    end
  end

  // frequency and band test
  logic [SumW-1:0] fprod;
  logic [31:0]     f_q;
  logic [55:0]     bprod_q;
  logic            started_q;
  logic [31:0]     band_start_q;

  assign fprod = freq_step_q * idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.freq) begin
      f_q <= (|fprod[SumW-1:32]) ? 32'hFFFF_FFFF : fprod[31:0];
    end
    if (cmd_i.bmul) begin
      bprod_q <= band_start_q * band_ratio_q;
    end
  end

  assign sts_o.close = started_q && ({8'h00, f_q, 16'h0000} > bprod_q);

  // CORDIC
  logic signed [XW-1:0] x_q, y_q, xs, ys, dx, dy;
  logic [31:0]          a_q;
  logic [CW-1:0]        i_q;
  logic                 zero_q;
  logic [XW-1:0]        xpos;
  logic [MW-1:0]        mprod;
  logic [XW-1:0]        mag_q;

  assign xs = {{(XW-32){re_q[23]}}, re_q, 8'h00};
  assign ys = {{(XW-32){im_q[23]}}, im_q, 8'h00};
  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;
  assign sts_o.cord_done = (i_q == CW'(CORDIC_STEPS - 1));
  assign xpos  = x_q[XW-1] ? '0 : x_q;
  assign mprod = {24'h000000, xpos} * MW'(InvGain) + MW'(32'h0080_0000);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cinit) begin
      zero_q <= (re_q == 24'sd0) && (im_q == 24'sd0);
      i_q    <= '0;
      if (re_q[23]) begin
        x_q <= -xs;
        y_q <= -ys;
        a_q <= 32'h8000_0000;
      end else begin
        x_q <= xs;
        y_q <= ys;
        a_q <= 32'h0000_0000;
      end
    end else if (cmd_i.citer) begin
      i_q <= i_q + 1'b1;
      if (!y_q[XW-1]) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        a_q <= a_q + atan_turn(5'(i_q));
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        a_q <= a_q - atan_turn(5'(i_q));
      end
    end
    if (cmd_i.mag) begin
      mag_q <= zero_q ? '0 : mprod[MW-1:24];
    end
  end

  // delay term and phase
  logic signed [64:0] dprod;
  logic [23:0]        fd_q, angr, ph, ds, prev_phase_q;
  logic [31:0]        asum;
  logic               indet;

  assign dprod = $signed({1'b0, f_q}) * $signed(delay_q);
  assign asum  = a_q + 32'd128;
  assign angr  = zero_q ? 24'h000000 : asum[31:8];
  assign ph    = 24'h000000 - angr - fd_q;
  assign ds    = ph - prev_phase_q;
  assign indet = ($signed(ds) > $signed(24'sd4194304)) ||
                 ($signed(ds) < $signed(-24'sd4194304));

  always_ff @(posedge clk_i) begin
    if (cmd_i.dmul) begin
      fd_q <= dprod[39:16];
    end
  end

  // band sums and counters
  logic [SumW-1:0]       freq_sum_q, mag_sum_q;
  logic [INDEX_BITS-1:0] count_q;
  logic [PhW-1:0]        phase_sum_q;
  logic [31:0]           span_start_q, prev_freq_q, indet_q, unwrap_q;
  logic                  pvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_sum_q   <= '0;
      mag_sum_q    <= '0;
      count_q      <= '0;
      phase_sum_q  <= '0;
      band_start_q <= '0;
      started_q    <= 1'b0;
      span_start_q <= '0;
      prev_freq_q  <= '0;
      prev_phase_q <= '0;
      pvalid_q     <= 1'b0;
      indet_q      <= '0;
      unwrap_q     <= '0;
    end else begin
      if (cmd_i.band_open && !started_q) begin
        band_start_q <= f_q;
        started_q    <= 1'b1;
      end
      if (cmd_i.upd) begin
        freq_sum_q  <= freq_sum_q + SumW'(f_q);
        mag_sum_q   <= mag_sum_q + SumW'(mag_q);
        count_q     <= count_q + 1'b1;
        prev_freq_q <= f_q;
        prev_phase_q <= ph;
        if (pvalid_q) begin
          phase_sum_q <= phase_sum_q + {{(PhW-24){ds[23]}}, ds};
          unwrap_q    <= unwrap_q + 32'd1;
          if (indet) begin
            indet_q <= indet_q + 32'd1;
          end
        end else begin
          span_start_q <= f_q;
          pvalid_q     <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        freq_sum_q  <= '0;
        mag_sum_q   <= '0;
        count_q     <= '0;
        phase_sum_q <= '0;
        if (cmd_i.emit_last) begin
          band_start_q <= '0;
          started_q    <= 1'b0;
          span_start_q <= '0;
          prev_freq_q  <= '0;
          prev_phase_q <= '0;
          pvalid_q     <= 1'b0;
        end else begin
          span_start_q <= prev_freq_q;
          band_start_q <= f_q;
        end
      end
    end
  end

  // band close arithmetic
  logic [PhW-1:0]  ps_abs;
  logic            ps_neg, span_neg, cnt_zero, gd_zero;
  logic [32:0]     span, span_abs;
  logic [DW-1:0]   div_a, quo;
  logic [31:0]     div_b, avg, gd;
  logic            div_busy;
  logic [31:0]     mf_q;
  logic [55:0]     sprod_q;
  logic [39:0]     mm;

  assign ps_neg   = phase_sum_q[PhW-1];
  assign ps_abs   = ps_neg ? (~phase_sum_q + 1'b1) : phase_sum_q;
  assign span     = {1'b0, prev_freq_q} - {1'b0, span_start_q};
  assign span_neg = span[32];
  assign span_abs = span_neg ? (~span + 1'b1) : span;
  assign cnt_zero = (count_q == '0);
  assign gd_zero  = (span == '0) || (phase_sum_q == '0);
  assign avg      = cnt_zero ? 32'h0 : ((|quo[DW-1:32]) ? 32'hFFFF_FFFF : quo[31:0]);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_FREQ: begin
        div_a = DW'(freq_sum_q);
        div_b = 32'(count_q);
      end
      DIV_MAG: begin
        div_a = DW'(mag_sum_q);
        div_b = 32'(count_q);
      end
      DIV_GD: begin
        div_a = {ps_abs, 16'h0000};
        div_b = span_abs[31:0];
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  lsbgd_div #(.DW(DW), .VW(32)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign sts_o.div_busy = div_busy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_f) begin
      mf_q <= avg;
    end
    if (cmd_i.smul) begin
      sprod_q <= avg * mag_scale_q;
    end
  end

  assign mm = (|sprod_q[55:48]) ? 40'hFF_FFFF_FFFF : sprod_q[47:8];

  always_comb begin
    if (gd_zero) begin
      gd = 32'h0;
    end else if (ps_neg != span_neg) begin
      gd = (quo > DW'(32'h8000_0000)) ? 32'h8000_0000 : (32'h0 - quo[31:0]);
    end else begin
      gd = (quo > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[31:0];
    end
  end

  // result register
  logic out_valid_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.last     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mean_freq_o           <= mf_q;
      mean_mag_o            <= mm;
      group_delay_o         <= gd;
      indeterminate_total_o <= indet_q;
      unwrap_total_o        <= unwrap_q;
      last_row_o            <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lsbgd_pkg::*;

  // Index past the register map; the block must ignore the write.
  localparam logic [CfgIdxW-1:0] RegUnmapped = 8'd9;
  // Idle wait after the last result, long enough for a bin that gives no
  // result to finish its CORDIC and update, with margin.
  localparam int DrainCycles = 400;
  localparam int TotalBins   = 1300;

  typedef struct {
    logic [31:0] mean_freq;
    logic [39:0] mean_mag;
    logic [31:0] group_delay;
    logic [31:0] indet;
    logic [31:0] unwrap;
    logic        last_row;
  } band_row_t;

  typedef struct {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic [15:0]        idx;
    logic               fin;
    logic               last;
  } bin_t;

  typedef struct {
    bin_t      b;
    bit        typed;
    band_row_t row;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [23:0] re_part_i;
  logic signed [23:0] im_part_i;
  logic [15:0] bin_index_i;
  logic finite_i;
  logic last_bin_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [31:0] mean_freq_o;
  logic [39:0] mean_mag_o;
  logic signed [31:0] group_delay_o;
  logic [31:0] indeterminate_total_o;
  logic [31:0] unwrap_total_o;
  logic last_row_o;

  log_spectrum_binner_group_delay_core i_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .re_part_i, .im_part_i, .bin_index_i,
    .finite_i, .last_bin_i,
    .out_valid_o, .out_stall_i, .mean_freq_o, .mean_mag_o, .group_delay_o,
    .indeterminate_total_o, .unwrap_total_o, .last_row_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop for a hung handshake.
  initial begin
    #(100ms);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: register shadow and band state
  // ---------------------------------------------------------------------------
  logic [31:0] freq_step_q;
  logic [23:0] band_ratio_q;
  logic [23:0] mag_scale_q;
  logic [31:0] delay_comp_q;

  logic [47:0] freq_acc, mag_acc;
  logic [15:0] bin_cnt;
  logic [39:0] step_acc;
  logic [31:0] band_lo_f, span_lo_f, prev_f;
  logic [23:0] prev_ph;
  bit          band_open, ph_valid;
  logic [31:0] indet_cnt, unwrap_cnt;

  band_row_t pending_rows[$];
  int        errors;
  int        bins_sent;
  bit        quiet_tx, quiet_rx;

  function automatic void clear_band();
    freq_acc = '0; mag_acc = '0; bin_cnt = '0; step_acc = '0;
  endfunction

  function automatic void clear_spectrum();
    clear_band();
    band_lo_f = '0; band_open = 0; span_lo_f = '0; prev_f = '0;
    prev_ph = '0; ph_valid = 0;
  endfunction

  // Vectoring CORDIC; x, y carry 8 extra fraction bits, angle in Q0.32 turns.
  function automatic void cordic_polar(input logic signed [23:0] re,
                                       input logic signed [23:0] im,
                                       output longint unsigned mag,
                                       output logic [31:0] ang);
    longint signed x, y, dx, dy;
    x = re;
    y = im;
    x = x * 256;
    y = y * 256;
    ang = '0;
    if (re == 0 && im == 0) begin
      mag = 0;
      return;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < CordicStepsDef; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += atan_turn(i[4:0]);
      end else begin
        x -= dx; y += dy; ang -= atan_turn(i[4:0]);
      end
    end
    if (x < 0) x = 0;
    mag = (longint'(x) * longint'(InvGain) + 64'd8388608) >> 24;
  endfunction

  function automatic band_row_t band_report(bit flush);
    band_row_t r;
    longint signed ps, span, hi, lo;
    longint unsigned avg, mf, mm, an, ad, q;
    r.mean_freq = '0; r.mean_mag = '0; r.group_delay = '0;
    ps = $signed(step_acc);
    hi = prev_f;
    lo = span_lo_f;
    span = hi - lo;
    if (bin_cnt != 0) begin
      avg = mag_acc / bin_cnt;
      mf = freq_acc / bin_cnt;
      if (mf > 64'hFFFF_FFFF) mf = 64'hFFFF_FFFF;
      if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
      mm = (avg * mag_scale_q) >> 8;
      if (mm > 64'hFF_FFFF_FFFF) mm = 64'hFF_FFFF_FFFF;
      r.mean_freq = mf[31:0];
      r.mean_mag = mm[39:0];
    end
    if (span != 0 && ps != 0) begin
      an = (ps < 0 ? -ps : ps) << 16;
      ad = span < 0 ? -span : span;
      q = an / ad;
      if ((ps < 0) != (span < 0)) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        r.group_delay = 32'(0 - q);
      end else begin
        r.group_delay = q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
      end
    end
    r.indet = indet_cnt;
    r.unwrap = unwrap_cnt;
    r.last_row = flush;
    return r;
  endfunction

  // Fold one accepted bin into the band state; results go to rows.
  function automatic void predict_bin(bin_t b, ref band_row_t rows[$]);
    longint unsigned f, mag, dl, fd, ph;
    logic [31:0] ang;
    logic signed [23:0] ds;
    rows.delete();
    if (b.fin) begin
      f = longint'(freq_step_q) * b.idx;
      if (f > 64'hFFFF_FFFF) f = 64'hFFFF_FFFF;
      if (band_open && (f << 16) > longint'(band_lo_f) * band_ratio_q) begin
        rows.push_back(band_report(0));
        clear_band();
        span_lo_f = prev_f;
        band_lo_f = f[31:0];
      end else if (!band_open) begin
        band_lo_f = f[31:0];
        band_open = 1;
      end
      freq_acc += f[47:0];
      cordic_polar(b.re, b.im, mag, ang);
      mag_acc += mag[47:0];
      bin_cnt += 1;
      dl = {{32{delay_comp_q[31]}}, delay_comp_q};
      fd = ((f * dl) >> 16) & 64'hFF_FFFF;
      ph = (0 - (((longint'(ang) + 128) >> 8) & 64'hFF_FFFF) - fd) & 64'hFF_FFFF;
      if (ph_valid) begin
        ds = ph[23:0] - prev_ph;
        if (ds > 24'sd4194304 || ds < -24'sd4194304) indet_cnt++;
        step_acc += {{16{ds[23]}}, ds};
        unwrap_cnt++;
      end else begin
        span_lo_f = f[31:0];
        ph_valid = 1;
      end
      prev_f = f[31:0];
      prev_ph = ph[23:0];
    end
    if (b.last) begin
      rows.push_back(band_report(1));
      clear_spectrum();
    end
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic bit rows_match(band_row_t a, band_row_t b);
    return a.mean_freq == b.mean_freq && a.mean_mag == b.mean_mag &&
           a.group_delay == b.group_delay && a.indet == b.indet &&
           a.unwrap == b.unwrap && a.last_row == b.last_row;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, field-wise check against the oldest row
  // ---------------------------------------------------------------------------
  int stall_left;

  always @(posedge clk_i) begin
    band_row_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rows.size() == 0) begin
        $display("%0t unexpected result transfer", $realtime);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        if (mean_freq_o !== want.mean_freq) report("mean_freq", mean_freq_o, want.mean_freq);
        if (mean_mag_o !== want.mean_mag) report("mean_mag", mean_mag_o, want.mean_mag);
        if (group_delay_o !== want.group_delay)
          report("group_delay", 32'(group_delay_o), want.group_delay);
        if (indeterminate_total_o !== want.indet)
          report("indeterminate_total", indeterminate_total_o, want.indet);
        if (unwrap_total_o !== want.unwrap) report("unwrap_total", unwrap_total_o, want.unwrap);
        if (last_row_o !== want.last_row) report("last_row", last_row_o, want.last_row);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (quiet_rx || $urandom_range(99) < 65) begin
      out_stall_i <= 1'b0;
    end else begin
      // mostly short holds, now and then a long one
      stall_left = ($urandom_range(99) < 85) ? $urandom_range(2, 0) : $urandom_range(60, 10);
      out_stall_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Bin side
  // ---------------------------------------------------------------------------
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(99);
    if (quiet_tx || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Called right after an edge; returns at the edge that takes the transfer.
  task automatic send_bin(bin_t b, bit typed = 0, band_row_t typed_row = '{default: '0});
    band_row_t rows[$];
    int g;
    g = gap_cycles();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    re_part_i   <= b.re;
    im_part_i   <= b.im;
    bin_index_i <= b.idx;
    finite_i    <= b.fin;
    last_bin_i  <= b.last;
    do @(posedge clk_i); while (in_stall_o);
    predict_bin(b, rows);
    if (typed) begin
      // table value stands as the expectation; predictor must agree with it
      if (rows.size() != 1 || !rows_match(rows[0], typed_row)) begin
        $display("%0t predictor disagrees with table row at bin %0d", $realtime, b.idx);
        errors++;
      end
      pending_rows.push_back(typed_row);
    end else begin
      foreach (rows[i]) pending_rows.push_back(rows[i]);
    end
    bins_sent++;
  endtask

  // Block idle: every result in, then the no-result latency on top.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegFreqStep:  freq_step_q  = data;
      RegBandRatio: band_ratio_q = data[23:0];
      RegMagScale:  mag_scale_q  = data[23:0];
      RegDelayComp: delay_comp_q = data;
      default: ;
    endcase
  endtask

  function automatic logic [23:0] rand_part();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(2000)) - 1000);
      2: begin
        case ($urandom_range(4))
          0: return 24'h7F_FFFF;
          1: return 24'h80_0000;
          2: return 24'h00_0001;
          3: return 24'hFF_FFFF;
          default: return 24'h00_0000;
        endcase
      end
      default: return 24'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  // One spectrum: ascending bins, a few skipped, last one flushes.
  // Some runs are noise instead: random order, random flags.
  task automatic run_spectrum();
    bin_t b;
    int   len;
    int   idx;
    bit   noise;
    noise = $urandom_range(99) < 8;
    len = noise ? $urandom_range(6, 1)
                : ($urandom_range(99) < 90 ? $urandom_range(30, 1) : $urandom_range(90, 31));
    idx = ($urandom_range(99) < 70) ? $urandom_range(50, 1) : $urandom_range(65000, 1);
    for (int i = 0; i < len; i++) begin
      b.re = rand_part();
      b.im = rand_part();
      if (noise) begin
        b.idx  = 16'($urandom);
        b.fin  = $urandom_range(1);
        b.last = $urandom_range(1);
      end else begin
        b.idx  = 16'(idx);
        b.fin  = $urandom_range(11) != 0;
        b.last = (i == len - 1) || idx >= 65535;
        idx    = idx + $urandom_range(3, 1);
        if (idx > 65535) idx = 65535;
      end
      send_bin(b);
      if (!noise && b.last) break;
    end
  endtask

  // Directed bins under reset settings (freq_step 256, ratio about 1.06).
  dir_row_t dir_tab[] = '{
    // skipped bin that flushes an empty spectrum
    '{'{24'sd0, 24'sd0, 16'd1, 1'b0, 1'b1}, 1, '{32'd0, 40'd0, 32'd0, 32'd0, 32'd0, 1'b1}},
    // lone zero bin: magnitude zero, single-bin band has zero span
    '{'{24'sd0, 24'sd0, 16'd1, 1'b1, 1'b1}, 1, '{32'd256, 40'd0, 32'd0, 32'd0, 32'd0, 1'b1}},
    '{'{24'sd8388607, 24'sd0, 16'd1, 1'b1, 1'b0}, 0, '{default: '0}},
    '{'{-24'sd8388608, 24'sd0, 16'd2, 1'b1, 1'b0}, 0, '{default: '0}},
    '{'{24'sd0, 24'sd8388607, 16'd3, 1'b1, 1'b0}, 0, '{default: '0}},
    '{'{24'sd0, -24'sd8388608, 16'd4, 1'b1, 1'b0}, 0, '{default: '0}},
    '{'{-24'sd8388608, -24'sd8388608, 16'd5, 1'b1, 1'b0}, 0, '{default: '0}},
    '{'{24'sd8388607, 24'sd8388607, 16'd6, 1'b0, 1'b0}, 0, '{default: '0}},
    '{'{24'sd1, -24'sd1, 16'd6, 1'b1, 1'b0}, 0, '{default: '0}},
    '{'{-24'sd1, 24'sd1, 16'd40000, 1'b1, 1'b0}, 0, '{default: '0}},
    // out of order: bins descend inside one band
    '{'{24'sd1000, 24'sd2000, 16'd39999, 1'b1, 1'b0}, 0, '{default: '0}},
    '{'{24'sd9000, -24'sd2000, 16'd39990, 1'b1, 1'b0}, 0, '{default: '0}},
    // close and flush on one bin
    '{'{24'sd123, -24'sd456, 16'd65535, 1'b1, 1'b1}, 0, '{default: '0}},
    '{'{24'sd5, 24'sd0, 16'd7, 1'b0, 1'b0}, 0, '{default: '0}},
    '{'{24'sd300, 24'sd7, 16'd65535, 1'b1, 1'b1}, 0, '{default: '0}},
    // phase swinging by more than a quarter turn
    '{'{24'sd1000, 24'sd0, 16'd10, 1'b1, 1'b0}, 0, '{default: '0}},
    '{'{-24'sd1000, 24'sd1, 16'd11, 1'b1, 1'b0}, 0, '{default: '0}},
    '{'{24'sd1000, 24'sd0, 16'd12, 1'b1, 1'b0}, 0, '{default: '0}},
    '{'{24'sd0, 24'sd1000, 16'd13, 1'b1, 1'b0}, 0, '{default: '0}},
    '{'{24'sd0, -24'sd1000, 16'd14, 1'b1, 1'b1}, 0, '{default: '0}}
  };

  // Register settings for the first four phases; the first two are the extremes.
  logic [31:0] phase_cfg[4][4] = '{
    '{32'd1, 32'd65537, 32'd0, 32'h8000_0000},
    '{32'hFFFF_FFFF, 32'd16777215, 32'd16777215, 32'h7FFF_FFFF},
    '{32'd256, 32'd69433, 32'd65536, 32'd0},
    '{32'd37, 32'd131072, 32'd1000, 32'h0010_0000}
  };

  initial begin
    int nphase;
    int per_phase;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    re_part_i = '0;
    im_part_i = '0;
    bin_index_i = 16'd1;
    finite_i = 1'b0;
    last_bin_i = 1'b0;
    out_stall_i = 1'b0;
    stall_left = 0;
    errors = 0;
    bins_sent = 0;
    quiet_tx = 0;
    quiet_rx = 0;
    freq_step_q = 32'd256;
    band_ratio_q = 24'd69433;
    mag_scale_q = 24'd65536;
    delay_comp_q = 32'd0;
    indet_cnt = '0;
    unwrap_cnt = '0;
    clear_spectrum();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under reset settings
    foreach (dir_tab[i]) send_bin(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].row);

    // random phases: fixed settings first, then random ones
    nphase = 8;
    per_phase = (TotalBins - bins_sent) / nphase;
    for (int p = 0; p < nphase; p++) begin
      // sender holds off here until the block has drained
      wait_idle();
      if (p < 4) begin
        write_reg(RegFreqStep, phase_cfg[p][0]);
        write_reg(RegBandRatio, phase_cfg[p][1]);
        write_reg(RegMagScale, phase_cfg[p][2]);
        write_reg(RegDelayComp, phase_cfg[p][3]);
        if (p == 0) write_reg(RegUnmapped, $urandom);
      end else begin
        write_reg(RegFreqStep, ($urandom_range(3) == 0) ? ($urandom | 32'd1)
                                                         : $urandom_range(4096, 1));
        write_reg(RegBandRatio, $urandom_range(3) == 0 ? $urandom_range(16777215, 65537)
                                                       : $urandom_range(200000, 65537));
        write_reg(RegMagScale, $urandom_range(16777215));
        write_reg(RegDelayComp, $urandom);
      end
      // one phase runs with no idling on either side
      quiet_tx = (p == 2);
      quiet_rx = (p == 2);
      while (bins_sent < per_phase * (p + 1) + dir_tab.size()) run_spectrum();
    end

    quiet_tx = 0;
    quiet_rx = 0;
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: log_spectrum_binner_group_delay_core.f
sv/lsbgd_pkg.sv
sv/lsbgd_div.sv
sv/lsbgd_ctrl.sv
sv/lsbgd_dp.sv
sv/log_spectrum_binner_group_delay_core.sv
verif/tb_top.sv
